// File: hdl/soh_length_frame_receiver_macros.svh
// Assertion helpers for the frame receiver checker.
`ifndef SOH_LENGTH_FRAME_RECEIVER_MACROS_SVH
`define SOH_LENGTH_FRAME_RECEIVER_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define SLFR_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) else $error(msg);

// Check that a trigger in one cycle is followed by a condition in the next.
`define SLFR_ASSERT_NEXT(lbl, clk_s, rst_s, trig, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (trig) |=> (cond)) \
    else $error(msg);

`endif

// File: hdl/slfr_pkg.sv
package slfr_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] slot_t;

  typedef enum logic [1:0] {
    OP_RECV    = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2
  } opcode_t;

  // Start byte, length and inverted length precede the payload.
  localparam int HDR_BYTES = 3;

  localparam byte_t START_RESET = 8'hAA;

  localparam byte_t POS_START   = 8'd0;
  localparam byte_t POS_LEN     = 8'd1;
  localparam byte_t POS_LEN_INV = 8'd2;
  localparam byte_t POS_PAYLOAD = 8'd3;

endpackage

// File: hdl/slfr_if.sv
interface slfr_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  slfr_pkg::byte_t     byte_value;
  slfr_pkg::slot_t     slot_select;
  slfr_pkg::byte_t     byte_offset;

  modport source (output valid, opcode, byte_value, slot_select, byte_offset, input ready);
  modport sink   (input valid, opcode, byte_value, slot_select, byte_offset, output ready);
endinterface

interface slfr_out_if;
  logic                valid;
  logic                ready;
  slfr_pkg::byte_t     read_data;
  slfr_pkg::slot_t     write_slot;
  slfr_pkg::slot_t     oldest_slot;
  logic                frame_done;
  logic                frame_dropped;
  slfr_pkg::byte_t     frame_position;

  modport source (output valid, read_data, write_slot, oldest_slot, frame_done, frame_dropped,
                  frame_position, input ready);
  modport sink   (input valid, read_data, write_slot, oldest_slot, frame_done, frame_dropped,
                  frame_position, output ready);
endinterface

// File: hdl/slfr_ram.sv
module slfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/soh_length_frame_receiver.sv
// Frame receiver for start byte / length / inverted length framed serial data, storing each
// frame into one of SLOT_COUNT slots of SLOT_BYTES bytes in a single frame-store RAM
// (SLOT_COUNT*SLOT_BYTES bytes). A new item is taken each cycle the result register is empty
// or being drained, and its result appears in the cycle after acceptance, when the registered
// RAM read port delivers data for a read opcode. Each item does at most one RAM access (a write
// for a received byte, a read for a read opcode), so the rate is one item per clock while the
// output is not stalled. The store is not cleared; reading a byte of a slot never written
// returns undefined data. Configure start_byte only while no transaction is outstanding.
module soh_length_frame_receiver #(
  parameter int SLOT_BYTES = 128,
  parameter int SLOT_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  slfr_in_if.sink             in_ch,
  slfr_out_if.source          out_ch,
  input  logic                cfg_we,
  input  slfr_pkg::byte_t     cfg_wdata
);

  localparam int DEPTH  = SLOT_COUNT * SLOT_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam slfr_pkg::byte_t LEN_MAX = 8'(SLOT_BYTES - slfr_pkg::HDR_BYTES);
  localparam slfr_pkg::slot_t LAST_SLOT = 4'(SLOT_COUNT - 1);

  slfr_pkg::byte_t start_r;
  slfr_pkg::byte_t pos_r, pos_nxt;
  slfr_pkg::byte_t left_r, left_nxt;
  slfr_pkg::byte_t len_r, len_nxt;
  slfr_pkg::slot_t fill_r, fill_nxt;
  slfr_pkg::slot_t cons_r, cons_nxt;
  logic            out_valid_r;
  logic            done_r, done_nxt;
  logic            dropped_r, dropped_nxt;
  logic            rd_hit_r, rd_hit_nxt;

  logic            in_acc;
  logic            we;
  slfr_pkg::byte_t wpos;
  slfr_pkg::byte_t wdata;
  logic            complete;
  logic            bad;
  slfr_pkg::byte_t clamp;
  slfr_pkg::byte_t left_dec;
  slfr_pkg::slot_t fill_inc;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  slfr_pkg::byte_t ram_q;

  function automatic slfr_pkg::slot_t next_slot(slfr_pkg::slot_t s);
    return (s == LAST_SLOT) ? '0 : s + 4'd1;
  endfunction

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign clamp    = (len_r > LEN_MAX) ? LEN_MAX : len_r;
  assign bad      = len_r != ~in_ch.byte_value;
  assign left_dec = (left_r != '0) ? left_r - 8'd1 : '0;
  assign fill_inc = next_slot(fill_r);

  always_comb begin
    pos_nxt     = pos_r;
    left_nxt    = left_r;
    len_nxt     = len_r;
    fill_nxt    = fill_r;
    cons_nxt    = cons_r;
    we          = 1'b0;
    wpos        = '0;
    wdata       = '0;
    complete    = 1'b0;
    done_nxt    = 1'b0;
    dropped_nxt = 1'b0;
    rd_hit_nxt  = 1'b0;
    case (slfr_pkg::opcode_t'(in_ch.opcode))
      slfr_pkg::OP_RECV: begin
        if (pos_r == slfr_pkg::POS_START) begin
          // drop stray idle bytes
          if (in_ch.byte_value == start_r) begin
            we      = 1'b1;
            wpos    = slfr_pkg::POS_START;
            wdata   = start_r;
            pos_nxt = slfr_pkg::POS_LEN;
          end
        end else if (pos_r == slfr_pkg::POS_LEN) begin
          we      = 1'b1;
          wpos    = slfr_pkg::POS_LEN;
          wdata   = in_ch.byte_value;
          len_nxt = in_ch.byte_value;
          pos_nxt = slfr_pkg::POS_LEN_INV;
        end else if (pos_r == slfr_pkg::POS_LEN_INV) begin
          if (bad && len_r == start_r) begin
            // started one byte early: take this byte as the length
            we      = 1'b1;
            wpos    = slfr_pkg::POS_LEN;
            wdata   = in_ch.byte_value;
            len_nxt = in_ch.byte_value;
          end else if (bad && in_ch.byte_value == start_r) begin
            pos_nxt = slfr_pkg::POS_LEN;
          end else if (bad) begin
            pos_nxt = slfr_pkg::POS_START;
          end else begin
            we       = 1'b1;
            wpos     = slfr_pkg::POS_LEN_INV;
            wdata    = ~clamp;
            left_nxt = clamp;
            pos_nxt  = slfr_pkg::POS_PAYLOAD;
            complete = (clamp == '0);
          end
        end else begin
          we       = int'(pos_r) < SLOT_BYTES;
          wpos     = pos_r;
          wdata    = in_ch.byte_value;
          pos_nxt  = pos_r + 8'd1;
          left_nxt = left_dec;
          complete = (left_dec == '0);
        end
      end
      slfr_pkg::OP_READ: begin
        rd_hit_nxt = (int'(in_ch.slot_select) < SLOT_COUNT)
                  && (int'(in_ch.byte_offset) < SLOT_BYTES);
      end
      slfr_pkg::OP_RELEASE: begin
        if (cons_r != fill_r) begin
          cons_nxt = next_slot(cons_r);
        end
      end
      default: begin
      end
    endcase
    if (complete) begin
      pos_nxt  = '0;
      fill_nxt = fill_inc;
      done_nxt = 1'b1;
      // ring full: overwrite the oldest frame
      if (fill_inc == cons_r) begin
        cons_nxt    = next_slot(cons_r);
        dropped_nxt = 1'b1;
      end
    end
  end

  assign waddr = ADDR_W'(int'(fill_r) * SLOT_BYTES + int'(wpos));
  assign raddr = ADDR_W'(int'(in_ch.slot_select) * SLOT_BYTES + int'(in_ch.byte_offset));

  slfr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_acc && we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (in_acc && rd_hit_nxt),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= slfr_pkg::START_RESET;
      pos_r       <= '0;
      left_r      <= '0;
      fill_r      <= '0;
      cons_r      <= '0;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
      dropped_r   <= 1'b0;
      rd_hit_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        start_r <= cfg_wdata;
      end
      if (in_acc) begin
        pos_r       <= pos_nxt;
        left_r      <= left_nxt;
        fill_r      <= fill_nxt;
        cons_r      <= cons_nxt;
        done_r      <= done_nxt;
        dropped_r   <= dropped_nxt;
        rd_hit_r    <= rd_hit_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // length copy of slot byte one, always written in this frame before it is checked
  always_ff @(posedge clk) begin
    if (in_acc) begin
      len_r <= len_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_data      = rd_hit_r ? ram_q : '0;
  assign out_ch.write_slot     = fill_r;
  assign out_ch.oldest_slot    = cons_r;
  assign out_ch.frame_done     = done_r;
  assign out_ch.frame_dropped  = dropped_r;
  assign out_ch.frame_position = pos_r;

endmodule

// File: hdl/slfr_checker.sv
`include "soh_length_frame_receiver_macros.svh"

module slfr_assert_checker #(
  parameter int SLOT_COUNT = 4
) (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input slfr_pkg::byte_t read_data,
  input slfr_pkg::slot_t write_slot,
  input slfr_pkg::slot_t oldest_slot,
  input logic            frame_done,
  input logic            frame_dropped,
  input slfr_pkg::byte_t frame_position
);

  `SLFR_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid, "accepted transaction gave no result next cycle")
  `SLFR_ASSERT_ALWAYS(a_slots_in_ring, clk, rst_n, !out_valid || (int'(write_slot) < SLOT_COUNT && int'(oldest_slot) < SLOT_COUNT), "slot pointer beyond the ring")
  `SLFR_ASSERT_ALWAYS(a_drop_needs_done, clk, rst_n, !out_valid || !frame_dropped || frame_done, "frame dropped without completion")
  `SLFR_ASSERT_ALWAYS(a_done_rewinds, clk, rst_n, !out_valid || !frame_done || frame_position == '0, "completed frame left a nonzero position")
  `SLFR_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(write_slot) && $stable(frame_position), "stalled result changed")

endmodule

bind soh_length_frame_receiver slfr_assert_checker #(
  .SLOT_COUNT (SLOT_COUNT)
) u_slfr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .read_data      (out_ch.read_data),
  .write_slot     (out_ch.write_slot),
  .oldest_slot    (out_ch.oldest_slot),
  .frame_done     (out_ch.frame_done),
  .frame_dropped  (out_ch.frame_dropped),
  .frame_position (out_ch.frame_position)
);
